// File: src/gcm_pkg.sv
// shared types and constants for the greedy corner match block
package gcm_pkg;
	localparam int ImageSide = 64;
	localparam int CornerSlots = 32;
	localparam int WindowSide = 5;
	localparam int CfgW = 7;

	localparam logic [2:0] MODE_PIX1 = 3'd0;
	localparam logic [2:0] MODE_PIX2 = 3'd1;
	localparam logic [2:0] MODE_CRN1 = 3'd2;
	localparam logic [2:0] MODE_CRN2 = 3'd3;
	localparam logic [2:0] MODE_START = 3'd4;

	localparam logic [1:0] REG_W1 = 2'd0;
	localparam logic [1:0] REG_H1 = 2'd1;
	localparam logic [1:0] REG_W2 = 2'd2;
	localparam logic [1:0] REG_H2 = 2'd3;

	// controller to datapath
	typedef struct packed {
		logic run_clr;   // clear pair count at start
		logic a_set;     // select first corner i
		logic b_set;     // select second corner j
		logic cand_init; // clear best for new first corner
		logic u_clr;     // start used scan
		logic u_step;    // advance used scan
		logic sad_clr;   // clear window sum
		logic sad_step;  // issue one window pixel
		logic cand_eval; // compare candidate score
		logic emit_pair; // load pair into output reg
		logic emit_sum;  // load summary into output reg
	} gcm_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic a_fits;
		logic b_fits;
		logic used_hit;
		logic used_done;
		logic sad_done;
		logic found;
		logic pairs_full;
	} gcm_sts_t;
endpackage

// File: src/gcm_datapath.sv
// datapath: pixel and corner stores, window sad, best tracking and output register
module gcm_datapath #(
	parameter int CORNER_SLOTS = gcm_pkg::CornerSlots,
	parameter int WINDOW_SIDE = gcm_pkg::WindowSide,
	localparam int IMAGE_SIDE = gcm_pkg::ImageSide,
	localparam int CW = $clog2(IMAGE_SIDE),
	localparam int SW = $clog2(CORNER_SLOTS),
	localparam int NW = $clog2(CORNER_SLOTS + 1)
) (
	input  logic clk,
	input  logic arst_n,
	input  logic ld_en,
	input  logic [2:0] ld_mode,
	input  logic [5:0] ld_x,
	input  logic [5:0] ld_y,
	input  logic [23:0] ld_rgb,
	input  logic [6:0] w1,
	input  logic [6:0] h1,
	input  logic [6:0] w2,
	input  logic [6:0] h2,
	input  logic [SW-1:0] a_idx,
	input  logic [SW-1:0] b_idx,
	input  gcm_pkg::gcm_cmd_t cmd,
	output gcm_pkg::gcm_sts_t sts,
	output logic [NW-1:0] cnt1,
	output logic [NW-1:0] cnt2,
	output logic [45:0] res_data
);
	import gcm_pkg::*;

	localparam int HALF = WINDOW_SIDE / 2;
	localparam int WIN = WINDOW_SIDE * WINDOW_SIDE;
	localparam int WCW = $clog2(WIN + 1);
	localparam int KW = (WINDOW_SIDE > 1) ? $clog2(WINDOW_SIDE) : 1;
	localparam int SUMW = $clog2(WIN * 765 + 1);
	localparam int DW = CW + 1;

	logic [23:0] pix1_mem [IMAGE_SIDE*IMAGE_SIDE];
	logic [23:0] pix2_mem [IMAGE_SIDE*IMAGE_SIDE];
	logic [2*CW-1:0] crn1_q [CORNER_SLOTS];
	logic [2*CW-1:0] crn2_q [CORNER_SLOTS];
	logic [2*CW-1:0] used_q [CORNER_SLOTS];
	logic [NW-1:0] cnt1_q, cnt2_q, pairs_q, u_k_q;
	logic [2*CW-1:0] a_q, b_q, best_b_q;
	logic [SUMW-1:0] best_q, sum_q;
	logic found_q;
	logic [KW-1:0] wi_q, wj_q;
	logic [WCW-1:0] issued_q, done_cnt_q;
	logic rd_v_s1, rd_v_s2;
	logic [23:0] p_s2, q_s2;
	logic [9:0] ad_s2;
	logic [45:0] res_q;

	logic [DW-1:0] cw1, ch1, cw2, ch2;
	logic ld_ok;
	logic [CW-1:0] ax, ay, bx, by;
	logic [CW-1:0] rx1, ry1, rx2, ry2;
	logic [9:0] ad_sum;

	function automatic logic [DW-1:0] clampd(input logic [6:0] d);
		if ({25'd0, d} > IMAGE_SIDE) return DW'(IMAGE_SIDE);
		return DW'(d);
	endfunction

	function automatic logic fits(input logic [CW-1:0] cx, input logic [CW-1:0] cy,
			input logic [DW-1:0] w, input logic [DW-1:0] h);
		return ({1'b0, cx} >= DW'(HALF)) && ({1'b0, cy} >= DW'(HALF)) &&
			({1'b0, cx} + DW'(HALF) < w) && ({1'b0, cy} + DW'(HALF) < h);
	endfunction

	function automatic logic [8:0] ad8(input logic [7:0] a, input logic [7:0] b);
		return (a > b) ? {1'b0, a - b} : {1'b0, b - a};
	endfunction

	assign cw1 = clampd(w1);
	assign ch1 = clampd(h1);
	assign cw2 = clampd(w2);
	assign ch2 = clampd(h2);
	assign ld_ok = ({26'd0, ld_x} < IMAGE_SIDE) && ({26'd0, ld_y} < IMAGE_SIDE);

	assign ax = a_q[2*CW-1:CW];
	assign ay = a_q[CW-1:0];
	assign bx = b_q[2*CW-1:CW];
	assign by = b_q[CW-1:0];
	assign rx1 = ax - CW'(HALF) + CW'(wi_q);
	assign ry1 = ay - CW'(HALF) + CW'(wj_q);
	assign rx2 = bx - CW'(HALF) + CW'(wi_q);
	assign ry2 = by - CW'(HALF) + CW'(wj_q);

	// pixel memories, each with a load write port and a separate window read address
	always_ff @(posedge clk) begin
		if (ld_en && ld_mode == MODE_PIX1 && ld_ok)
			pix1_mem[{ld_x[CW-1:0], ld_y[CW-1:0]}] <= ld_rgb;
		if (ld_en && ld_mode == MODE_PIX2 && ld_ok)
			pix2_mem[{ld_x[CW-1:0], ld_y[CW-1:0]}] <= ld_rgb;
		p_s2 <= pix1_mem[{rx1, ry1}];
		q_s2 <= pix2_mem[{rx2, ry2}];
	end

	always_ff @(posedge clk) begin
		if (ld_en && ld_mode == MODE_CRN1 && cnt1_q < NW'(CORNER_SLOTS))
			crn1_q[cnt1_q[SW-1:0]] <= {ld_x[CW-1:0], ld_y[CW-1:0]};
		if (ld_en && ld_mode == MODE_CRN2 && cnt2_q < NW'(CORNER_SLOTS))
			crn2_q[cnt2_q[SW-1:0]] <= {ld_x[CW-1:0], ld_y[CW-1:0]};
		if (cmd.emit_pair)
			used_q[pairs_q[SW-1:0]] <= best_b_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt1_q <= '0;
			cnt2_q <= '0;
		end else begin
			if (ld_en && ld_mode == MODE_CRN1 && cnt1_q < NW'(CORNER_SLOTS))
				cnt1_q <= cnt1_q + 1'b1;
			if (ld_en && ld_mode == MODE_CRN2 && cnt2_q < NW'(CORNER_SLOTS))
				cnt2_q <= cnt2_q + 1'b1;
		end
	end

	assign ad_sum = 10'(ad8(p_s2[23:16], q_s2[23:16])) +
		10'(ad8(p_s2[15:8], q_s2[15:8])) + 10'(ad8(p_s2[7:0], q_s2[7:0]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pairs_q <= '0;
			u_k_q <= '0;
			found_q <= 1'b0;
			rd_v_s1 <= 1'b0;
			rd_v_s2 <= 1'b0;
			issued_q <= '0;
			done_cnt_q <= '0;
			wi_q <= '0;
			wj_q <= '0;
		end else begin
			if (cmd.run_clr) pairs_q <= '0;
			else if (cmd.emit_pair) pairs_q <= pairs_q + 1'b1;
			if (cmd.u_clr) u_k_q <= '0;
			else if (cmd.u_step) u_k_q <= u_k_q + 1'b1;
			if (cmd.cand_init) found_q <= 1'b0;
			else if (cmd.cand_eval && (!found_q || sum_q < best_q)) found_q <= 1'b1;
			rd_v_s1 <= cmd.sad_step;
			rd_v_s2 <= rd_v_s1;
			if (cmd.sad_clr) begin
				issued_q <= '0;
				done_cnt_q <= '0;
				wi_q <= '0;
				wj_q <= '0;
			end else begin
				if (cmd.sad_step) begin
					issued_q <= issued_q + 1'b1;
					if (wj_q == KW'(WINDOW_SIDE - 1)) begin
						wj_q <= '0;
						wi_q <= wi_q + 1'b1;
					end else begin
						wj_q <= wj_q + 1'b1;
					end
				end
				if (rd_v_s2) done_cnt_q <= done_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		ad_s2 <= rd_v_s1 ? ad_sum : '0;
		if (cmd.a_set) a_q <= crn1_q[a_idx];
		if (cmd.b_set) b_q <= crn2_q[b_idx];
		if (cmd.sad_clr) sum_q <= '0;
		else if (rd_v_s2) sum_q <= sum_q + SUMW'(ad_s2);
		if (cmd.cand_eval && (!found_q || sum_q < best_q)) begin
			best_q <= sum_q;
			best_b_q <= b_q;
		end
		if (cmd.emit_pair)
			res_q <= {1'b0, 6'd0,
				(best_q > SUMW'(32767)) ? 15'h7fff : 15'(best_q),
				6'(best_b_q[CW-1:0]), 6'(best_b_q[2*CW-1:CW]), 6'(ay), 6'(ax)};
		else if (cmd.emit_sum)
			res_q <= {1'b1, (pairs_q > NW'(63)) ? 6'd63 : 6'(pairs_q), 39'd0};
	end

	// ad_s2 is registered from the cycle of rd_v_s1, so it lines up with rd_v_s2
	assign sts.a_fits = fits(ax, ay, cw1, ch1);
	assign sts.b_fits = fits(bx, by, cw2, ch2);
	assign sts.used_done = (u_k_q >= pairs_q);
	assign sts.used_hit = !sts.used_done && (used_q[u_k_q[SW-1:0]] == b_q);
	assign sts.sad_done = (done_cnt_q == WCW'(WIN)) && (issued_q == WCW'(WIN));
	assign sts.found = found_q;
	assign sts.pairs_full = (pairs_q >= NW'(CORNER_SLOTS));
	assign cnt1 = cnt1_q;
	assign cnt2 = cnt2_q;
	assign res_data = res_q;
endmodule

// File: src/gcm_ctrl.sv
// controller: load dispatch, match search sequencing and output handshake
module gcm_ctrl #(
	parameter int CORNER_SLOTS = gcm_pkg::CornerSlots,
	parameter int WINDOW_SIDE = gcm_pkg::WindowSide,
	localparam int SW = $clog2(CORNER_SLOTS),
	localparam int NW = $clog2(CORNER_SLOTS + 1)
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic [2:0] in_mode,
	output logic in_ready,
	output logic ld_en,
	output logic out_valid,
	input  logic out_ready,
	input  logic [NW-1:0] cnt1,
	input  logic [NW-1:0] cnt2,
	output logic [SW-1:0] a_idx,
	output logic [SW-1:0] b_idx,
	output gcm_pkg::gcm_cmd_t cmd,
	input  gcm_pkg::gcm_sts_t sts
);
	import gcm_pkg::*;

	localparam int WIN = WINDOW_SIDE * WINDOW_SIDE;
	localparam int WCW = $clog2(WIN + 1);

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_ASEL  = 10'b0000000010,
		S_ACHK  = 10'b0000000100,
		S_BSEL  = 10'b0000001000,
		S_BCHK  = 10'b0000010000,
		S_USCAN = 10'b0000100000,
		S_SAD   = 10'b0001000000,
		S_EVAL  = 10'b0010000000,
		S_EMIT  = 10'b0100000000,
		S_OUTW  = 10'b1000000000
	} state_t;

	state_t state_q, state_d;
	logic [NW-1:0] i_q, j_q;
	logic [WCW-1:0] iss_q;
	logic ov_q;
	logic acc;

	assign in_ready = (state_q == S_IDLE);
	assign acc = in_valid && in_ready;
	assign ld_en = acc;
	assign out_valid = ov_q;
	assign a_idx = i_q[SW-1:0];
	assign b_idx = j_q[SW-1:0];

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (acc && in_mode == MODE_START) begin
					cmd.run_clr = 1'b1;
					state_d = S_ASEL;
				end
			end
			S_ASEL: begin
				if (i_q < cnt1) begin
					cmd.a_set = 1'b1;
					cmd.cand_init = 1'b1;
					state_d = S_ACHK;
				end else if (!ov_q || out_ready) begin
					cmd.emit_sum = 1'b1;
					state_d = S_OUTW;
				end
			end
			S_ACHK: state_d = sts.a_fits ? S_BSEL : S_EMIT;
			S_BSEL: begin
				if (j_q < cnt2) begin
					cmd.b_set = 1'b1;
					state_d = S_BCHK;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_BCHK: begin
				cmd.u_clr = 1'b1;
				cmd.sad_clr = 1'b1;
				state_d = sts.b_fits ? S_USCAN : S_BSEL;
			end
			S_USCAN: begin
				cmd.u_step = 1'b1;
				if (sts.used_hit) state_d = S_BSEL;
				else if (sts.used_done) state_d = S_SAD;
			end
			S_SAD: begin
				cmd.sad_step = (iss_q < WCW'(WIN));
				if (sts.sad_done) state_d = S_EVAL;
			end
			S_EVAL: begin
				cmd.cand_eval = 1'b1;
				state_d = S_BSEL;
			end
			S_EMIT: begin
				if (!sts.found || sts.pairs_full) state_d = S_ASEL;
				else if (!ov_q || out_ready) begin
					cmd.emit_pair = 1'b1;
					state_d = S_ASEL;
				end
			end
			S_OUTW: if (!ov_q || out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q <= '0;
			j_q <= '0;
			iss_q <= '0;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.run_clr) i_q <= '0;
			else if ((state_q == S_EMIT) && (state_d == S_ASEL)) i_q <= i_q + 1'b1;
			if (cmd.a_set) j_q <= '0;
			else if (cmd.b_set) j_q <= j_q + 1'b1;
			if (cmd.sad_clr) iss_q <= '0;
			else if (cmd.sad_step) iss_q <= iss_q + 1'b1;
			if (cmd.emit_pair || cmd.emit_sum) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end
endmodule

// File: src/greedy_corner_match_sad_core.sv
// Load items: one cycle each, back to back (tready high while idle).
// Start item: per first corner a select and fit check plus, per second corner, a select and
// fit check, a used scan over the pairs so far and WINDOW_SIDE^2 window pixel reads.
// One result register; the search stalls while a result waits.
// arst_n clears the controller and corner counts and sets the size registers to 64; pixel and
// corner stores are undefined until written.
module greedy_corner_match_sad_core #(
	parameter int CORNER_SLOTS = gcm_pkg::CornerSlots,
	parameter int WINDOW_SIDE = gcm_pkg::WindowSide
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [39:0] s_tdata, // mode, pos_x, pos_y, red, green, blue
	output logic m_tvalid,
	input  logic m_tready,
	output logic [47:0] m_tdata, // first_corner_x, first_corner_y, second_corner_x,
	                             // second_corner_y, match_error, match_total
	output logic m_tlast,        // is_last
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [6:0] cfg_data
);
	import gcm_pkg::*;

	localparam int SW = $clog2(CORNER_SLOTS);
	localparam int NW = $clog2(CORNER_SLOTS + 1);

	logic [6:0] w1_q, h1_q, w2_q, h2_q;
	logic ld_en;
	logic [NW-1:0] cnt1, cnt2;
	logic [SW-1:0] a_idx, b_idx;
	gcm_cmd_t cmd;
	gcm_sts_t sts;
	logic [45:0] res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w1_q <= 7'd64;
			h1_q <= 7'd64;
			w2_q <= 7'd64;
			h2_q <= 7'd64;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_W1: w1_q <= cfg_data;
				REG_H1: h1_q <= cfg_data;
				REG_W2: w2_q <= cfg_data;
				REG_H2: h2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	gcm_ctrl #(.CORNER_SLOTS(CORNER_SLOTS), .WINDOW_SIDE(WINDOW_SIDE)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_mode(s_tdata[2:0]),
		.in_ready(s_tready), .ld_en(ld_en), .out_valid(m_tvalid), .out_ready(m_tready),
		.cnt1(cnt1), .cnt2(cnt2), .a_idx(a_idx), .b_idx(b_idx), .cmd(cmd), .sts(sts)
	);

	gcm_datapath #(.CORNER_SLOTS(CORNER_SLOTS), .WINDOW_SIDE(WINDOW_SIDE)) u_dp (
		.clk(clk), .arst_n(arst_n), .ld_en(ld_en), .ld_mode(s_tdata[2:0]),
		.ld_x(s_tdata[8:3]), .ld_y(s_tdata[14:9]), .ld_rgb({s_tdata[22:15],
		s_tdata[30:23], s_tdata[38:31]}), .w1(w1_q), .h1(h1_q), .w2(w2_q), .h2(h2_q),
		.a_idx(a_idx), .b_idx(b_idx), .cmd(cmd), .sts(sts), .cnt1(cnt1), .cnt2(cnt2),
		.res_data(res)
	);

	assign m_tdata = {3'd0, res[44:0]};
	assign m_tlast = res[45] & m_tvalid;

`ifndef SYNTHESIS
	a_one_emit: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.emit_pair && cmd.emit_sum)) else $error("double emit");
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sad_step |-> !s_tready) else $error("accept during search");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(res)) else $error("result changed");
`endif
endmodule

// File: tb/sv/tb_greedy_corner_match_sad_core.sv
// testbench for the greedy corner match core: stream stimulus, own predictor, result checks
`timescale 1ns / 1ps
module tb_greedy_corner_match_sad_core;
	import gcm_pkg::*;

	typedef struct packed {
		logic [5:0] fx;
		logic [5:0] fy;
		logic [5:0] sx;
		logic [5:0] sy;
		logic [14:0] err;
		logic [5:0] total;
		logic last;
	} match_t;

	typedef struct {
		logic [2:0] mode;
		logic [5:0] x;
		logic [5:0] y;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		bit typed;
		match_t want;
	} stim_row_t;

	localparam int IdleLimit = 200000;
	localparam int Half = WindowSide / 2;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [39:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic m_tlast;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [6:0] cfg_data = '0;

	greedy_corner_match_sad_core u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [23:0] img1 [ImageSide*ImageSide];
	logic [23:0] img2 [ImageSide*ImageSide];
	logic [11:0] list1 [CornerSlots];
	logic [11:0] list2 [CornerSlots];
	logic [11:0] taken [CornerSlots];
	int n1, n2, pairs;
	logic [6:0] dim [4];

	match_t match_q[$];
	int mismatches = 0;
	int idle_cycles = 0;
	int burst_left = 1;
	bit hold_go = 0;

	function automatic bit fits(int cx, int cy, int w, int h);
		return cx >= Half && cy >= Half && cx + Half < w && cy + Half < h;
	endfunction

	function automatic int clampd(logic [6:0] d);
		return (d > ImageSide) ? ImageSide : int'(d);
	endfunction

	function automatic int window_sad(int ax, int ay, int bx, int by);
		int sum;
		logic [23:0] p, q;
		sum = 0;
		for (int i = 0; i < WindowSide; i++)
			for (int j = 0; j < WindowSide; j++) begin
				p = img1[(ax - Half + i) * ImageSide + (ay - Half + j)];
				q = img2[(bx - Half + i) * ImageSide + (by - Half + j)];
				for (int c = 0; c < 3; c++) begin
					int u, v;
					u = p[c*8 +: 8];
					v = q[c*8 +: 8];
					sum += (u > v) ? u - v : v - u;
				end
			end
		return sum;
	endfunction

	task automatic run_match();
		int w1, h1, w2, h2, ax, ay, bx, by, best, s;
		logic [11:0] best_b;
		bit found, hit;
		match_t m;
		w1 = clampd(dim[REG_W1]);
		h1 = clampd(dim[REG_H1]);
		w2 = clampd(dim[REG_W2]);
		h2 = clampd(dim[REG_H2]);
		pairs = 0;
		for (int i = 0; i < n1; i++) begin
			ax = list1[i][11:6];
			ay = list1[i][5:0];
			found = 0;
			best = 0;
			best_b = '0;
			if (fits(ax, ay, w1, h1)) begin
				for (int j = 0; j < n2; j++) begin
					bx = list2[j][11:6];
					by = list2[j][5:0];
					hit = 0;
					for (int k = 0; k < pairs; k++)
						if (taken[k] == list2[j]) hit = 1;
					if (!hit && fits(bx, by, w2, h2)) begin
						s = window_sad(ax, ay, bx, by);
						if (!found || s < best) begin
							found = 1;
							best = s;
							best_b = list2[j];
						end
					end
				end
			end
			if (found && pairs < CornerSlots) begin
				taken[pairs] = best_b;
				pairs++;
				m = '0;
				m.fx = 6'(ax);
				m.fy = 6'(ay);
				m.sx = best_b[11:6];
				m.sy = best_b[5:0];
				m.err = (best > 32767) ? 15'h7fff : best[14:0];
				match_q.push_back(m);
			end
		end
		m = '0;
		m.total = (pairs > 63) ? 6'd63 : 6'(pairs);
		m.last = 1'b1;
		match_q.push_back(m);
	endtask

	task automatic apply_item(stim_row_t it);
		case (it.mode)
			MODE_PIX1: img1[it.x * ImageSide + it.y] = {it.r, it.g, it.b};
			MODE_PIX2: img2[it.x * ImageSide + it.y] = {it.r, it.g, it.b};
			MODE_CRN1: if (n1 < CornerSlots) list1[n1++] = {it.x, it.y};
			MODE_CRN2: if (n2 < CornerSlots) list2[n2++] = {it.x, it.y};
			MODE_START: run_match();
			default: ;
		endcase
	endtask

	task automatic send(stim_row_t it);
		int depth;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, it.b, it.g, it.r, it.y, it.x, it.mode};
		do @(posedge clk); while (!s_tready);
		depth = match_q.size();
		apply_item(it);
		if (it.typed) begin
			while (match_q.size() > depth) void'(match_q.pop_back());
			match_q.push_back(it.want);
		end
		burst_left--;
		if (burst_left <= 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
		end
	endtask

	task automatic drain();
		if (s_tvalid) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		while (match_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic cfg_write(logic [1:0] idx, logic [6:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		dim[idx] = val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// corner coordinates stay on the loaded patch or far enough out that no window fits
	function automatic logic [5:0] corner_coord();
		int v;
		v = $urandom_range(0, 9);
		return (v < 8) ? 6'(v) : (v == 8 ? 6'd62 : 6'd63);
	endfunction

	function automatic stim_row_t random_item();
		stim_row_t it;
		int r;
		it.typed = 0;
		it.want = '0;
		it.r = 8'($urandom);
		it.g = 8'($urandom);
		it.b = 8'($urandom);
		it.x = 6'($urandom);
		it.y = 6'($urandom);
		r = $urandom_range(0, 99);
		if (r < 70) begin
			it.mode = (r < 35) ? MODE_PIX1 : MODE_PIX2;
			if ($urandom_range(0, 4) != 0) begin
				it.x = 6'($urandom_range(0, 9));
				it.y = 6'($urandom_range(0, 9));
			end
		end else if (r < 90) begin
			it.mode = (r < 80) ? MODE_CRN1 : MODE_CRN2;
			it.x = corner_coord();
			it.y = corner_coord();
		end else if (r < 94) begin
			it.mode = 3'($urandom_range(5, 7));
		end else begin
			it.mode = MODE_START;
		end
		return it;
	endfunction

	// receiver: stall pattern of its own, plus one long hold on request
	initial begin
		int left, hold;
		bit rdy;
		left = 0;
		hold = 0;
		rdy = 0;
		forever begin
			@(negedge clk);
			if (hold_go && hold == 0) begin
				hold = 3000;
				hold_go = 0;
			end
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else begin
				if (left == 0) begin
					rdy = !rdy;
					left = rdy ? (($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 20))
						: $urandom_range(1, 6);
				end
				left--;
				m_tready <= rdy;
			end
		end
	end

	always @(posedge clk) begin
		match_t got;
		if (m_tvalid && m_tready) begin
			got = '0;
			got.fx = m_tdata[5:0];
			got.fy = m_tdata[11:6];
			got.sx = m_tdata[17:12];
			got.sy = m_tdata[23:18];
			got.err = m_tdata[38:24];
			got.total = m_tdata[44:39];
			got.last = m_tlast;
			if (match_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", got);
			end else if (got !== match_q[0]) begin
				mismatches++;
				if (mismatches <= 10) $display("mismatch: expected %p got %p", match_q[0], got);
				void'(match_q.pop_front());
			end else begin
				void'(match_q.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("FAILURE");
			$finish;
		end
	end

	stim_row_t directed [15];
	logic [6:0] phase_dims [5][4] = '{
		'{7'd64, 7'd64, 7'd64, 7'd64},
		'{7'd0, 7'd0, 7'd0, 7'd0},
		'{7'd127, 7'd127, 7'd127, 7'd127},
		'{7'd1, 7'd64, 7'd64, 7'd1},
		'{7'd10, 7'd9, 7'd64, 7'd12}
	};

	function automatic stim_row_t row(logic [2:0] md, logic [5:0] x, logic [5:0] y,
			logic [7:0] r, logic [7:0] g, logic [7:0] b);
		stim_row_t it;
		it.mode = md; it.x = x; it.y = y; it.r = r; it.g = g; it.b = b;
		it.typed = 0;
		it.want = '0;
		return it;
	endfunction

	initial begin
		stim_row_t it;
		n1 = 0;
		n2 = 0;
		pairs = 0;
		for (int i = 0; i < 4; i++) dim[i] = 7'd64;
		directed[0] = row(MODE_START, 0, 0, 0, 0, 0);
		directed[0].typed = 1;
		directed[0].want = '{fx: 0, fy: 0, sx: 0, sy: 0, err: 0, total: 0, last: 1};
		directed[1] = row(MODE_CRN1, 2, 2, 0, 0, 0);
		directed[2] = row(MODE_CRN1, 63, 63, 0, 0, 0);
		directed[3] = row(MODE_CRN1, 0, 0, 0, 0, 0);
		directed[4] = row(MODE_CRN1, 7, 7, 0, 0, 0);
		directed[5] = row(MODE_CRN2, 7, 7, 0, 0, 0);
		directed[6] = row(MODE_CRN2, 2, 2, 0, 0, 0);
		directed[7] = row(MODE_CRN2, 62, 0, 0, 0, 0);
		directed[8] = row(MODE_CRN2, 2, 2, 0, 0, 0);
		directed[9] = row(3'd5, 63, 63, 8'hff, 8'hff, 8'hff);
		directed[10] = row(3'd7, 0, 0, 0, 0, 0);
		directed[11] = row(MODE_PIX1, 0, 0, 8'hff, 8'hff, 8'hff);
		directed[12] = row(MODE_PIX2, 63, 63, 0, 0, 0);
		directed[13] = row(MODE_PIX2, 4, 4, 8'hff, 8'h00, 8'hff);
		directed[14] = row(MODE_START, 0, 0, 0, 0, 0);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// every pixel a fitting window can touch gets written first
		for (int x = 0; x < 10; x++)
			for (int y = 0; y < 10; y++) begin
				send(row(MODE_PIX1, 6'(x), 6'(y), 8'($urandom), 8'($urandom), 8'($urandom)));
				send(row(MODE_PIX2, 6'(x), 6'(y), 8'($urandom), 8'($urandom), 8'($urandom)));
			end
		foreach (directed[i]) send(directed[i]);
		drain();

		for (int p = 0; p < 5; p++) begin
			for (int r = 0; r < 4; r++) cfg_write(r[1:0], phase_dims[p][r]);
			if (p == 2) hold_go = 1;
			for (int k = 0; k < 50; k++) begin
				it = random_item();
				if (k == 5) it.mode = MODE_START;
				send(it);
			end
			if (p != 4) begin
				it = row(MODE_START, 0, 0, 0, 0, 0);
				send(it);
			end
			drain();
		end

		repeat (100) @(posedge clk);
		if (mismatches == 0 && match_q.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
